### src/dbpq_pkg.sv
package dbpq_pkg;

  localparam int CAPACITY    = 64;
  localparam int KEY_BITS    = 8;
  localparam int HANDLE_BITS = 16;
  localparam int CNT_BITS    = $clog2(CAPACITY + 1);

  localparam logic [1:0] KIND_ADD       = 2'd0;
  localparam logic [1:0] KIND_TAKE_LOW  = 2'd1;
  localparam logic [1:0] KIND_TAKE_HIGH = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [1:0] OP_HOLD     = 2'd0;
  localparam logic [1:0] OP_INSERT   = 2'd1;
  localparam logic [1:0] OP_POP_LOW  = 2'd2;
  localparam logic [1:0] OP_POP_HIGH = 2'd3;

  typedef struct packed {
    logic                   valid;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    logic [KEY_BITS-1:0]    top;
  } cmd_t;

endpackage

### src/dbpq_cell.sv
module dbpq_cell
  import dbpq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cmd_t   cmd,
  input  entry_t left_entry,
  input  logic   left_keep,
  input  logic   left_match,
  input  entry_t right_entry,
  output entry_t entry,
  output logic   keep,
  output logic   match,
  output logic   first
);

  entry_t entry_next;
  entry_t new_entry;

  assign keep  = entry.valid && (entry.key <= cmd.key);
  assign match = entry.valid && (entry.key == cmd.top);
  assign first = match && !left_match;

  always_comb begin
    new_entry.valid  = 1'b1;
    new_entry.key    = cmd.key;
    new_entry.handle = cmd.handle;
    entry_next = entry;
    case (cmd.op)
      OP_INSERT: begin
        // insert after every entry with key not above the new one
        if (!keep) begin
          entry_next = left_keep ? new_entry : left_entry;
        end
      end
      OP_POP_LOW: begin
        entry_next = right_entry;
      end
      OP_POP_HIGH: begin
        // close the gap left by the oldest entry of the top key group
        if (!entry.valid || match) begin
          entry_next = right_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.key    <= entry_next.key;
    entry.handle <= entry_next.handle;
  end

endmodule

### src/double_ended_bucket_priority_queue_unit.sv
// Bounded double-ended priority queue of CAPACITY items held in a sorted row
// of cells, ascending by key and in arrival order within a key. An add
// inserts in place (rejected with status full when the row is full); a take
// from the lowest or highest key returns the oldest item of that key group
// and the row closes the gap in the same cycle. Every transaction passes
// three steps: accept, a step that registers the highest key from the last
// valid cell, and one update of the whole row. The result is held in an output
// register, so one finished result may wait while the next transaction is
// accepted; the update stalls only if the previous result has not been taken.
module double_ended_bucket_priority_queue_unit
  import dbpq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             kind,
  input  logic [KEY_BITS-1:0]    key,
  input  logic [HANDLE_BITS-1:0] handle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic [HANDLE_BITS-1:0] item_handle,
  output logic [KEY_BITS-1:0]    item_key,
  output logic [CNT_BITS-1:0]    count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TOP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [1:0]             kind_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [KEY_BITS-1:0]    top_key;
  logic [KEY_BITS-1:0]    top_key_next;
  logic [CNT_BITS-1:0]    held;
  logic [CNT_BITS-1:0]    held_next;
  logic [1:0]             status_next;
  logic [HANDLE_BITS-1:0] sel_handle;
  logic [KEY_BITS-1:0]    sel_key;
  logic                   go;

  cmd_t   cmd;
  entry_t cell_entry [CAPACITY];
  entry_t cell_left  [CAPACITY];
  entry_t cell_right [CAPACITY];
  logic   cell_keep  [CAPACITY];
  logic   cell_match [CAPACITY];
  logic   cell_first [CAPACITY];
  logic   cell_lkeep [CAPACITY];
  logic   cell_lmatch[CAPACITY];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign cell_left[g]   = '0;
        assign cell_lkeep[g]  = 1'b1;
        assign cell_lmatch[g] = 1'b0;
      end else begin : g_body
        assign cell_left[g]   = cell_entry[g-1];
        assign cell_lkeep[g]  = cell_keep[g-1];
        assign cell_lmatch[g] = cell_match[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign cell_right[g] = '0;
      end else begin : g_mid
        assign cell_right[g] = cell_entry[g+1];
      end
      dbpq_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .left_entry  (cell_left[g]),
        .left_keep   (cell_lkeep[g]),
        .left_match  (cell_lmatch[g]),
        .right_entry (cell_right[g]),
        .entry       (cell_entry[g]),
        .keep        (cell_keep[g]),
        .match       (cell_match[g]),
        .first       (cell_first[g])
      );
    end
  endgenerate

  assign in_ready = (state == S_IDLE);
  assign go       = (state == S_EXEC) && (!out_valid || out_ready);

  // highest key sits in the last valid cell
  always_comb begin
    top_key_next = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_entry[i].valid &&
          ((i == CAPACITY - 1) || !cell_entry[(i + 1) % CAPACITY].valid)) begin
        top_key_next = top_key_next | cell_entry[i].key;
      end
    end
  end

  // pick the item leaving the row
  always_comb begin
    sel_handle = '0;
    sel_key    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if ((kind_r == KIND_TAKE_LOW) ? (i == 0) : cell_first[i]) begin
        sel_handle = sel_handle | cell_entry[i].handle;
        sel_key    = sel_key | cell_entry[i].key;
      end
    end
  end

  always_comb begin
    cmd.op      = OP_HOLD;
    cmd.key     = key_r;
    cmd.handle  = handle_r;
    cmd.top     = top_key;
    status_next = STATUS_DONE;
    held_next   = held;
    case (kind_r)
      KIND_ADD: begin
        if (held == CNT_BITS'(CAPACITY)) begin
          status_next = STATUS_FULL;
        end else begin
          cmd.op    = OP_INSERT;
          held_next = held + 1'b1;
        end
      end
      KIND_TAKE_LOW, KIND_TAKE_HIGH: begin
        if (held == '0) begin
          status_next = STATUS_EMPTY;
        end else begin
          cmd.op    = (kind_r == KIND_TAKE_LOW) ? OP_POP_LOW : OP_POP_HIGH;
          held_next = held - 1'b1;
        end
      end
      default: begin
        status_next = STATUS_DONE;
      end
    endcase
    if (!go) begin
      cmd.op = OP_HOLD;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (go) begin
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r   <= kind;
      key_r    <= key;
      handle_r <= handle;
    end
    if (state == S_TOP) begin
      top_key <= top_key_next;
    end
    if (go) begin
      status <= status_next;
      count  <= held_next;
      if (cmd.op == OP_POP_LOW || cmd.op == OP_POP_HIGH) begin
        item_handle <= sel_handle;
        item_key    <= sel_key;
      end else begin
        item_handle <= '0;
        item_key    <= '0;
      end
    end
  end

endmodule

### verif/double_ended_bucket_priority_queue_unit_test.sv
`timescale 1ns / 1ps

module double_ended_bucket_priority_queue_unit_test
  import dbpq_pkg::*;
();

  localparam int RANDOM_ITEMS = 850;
  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct {
    logic [1:0]             kind;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } queue_op_t;

  typedef struct {
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] item_handle;
    logic [KEY_BITS-1:0]    item_key;
    logic [CNT_BITS-1:0]    count;
  } queue_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             kind = KIND_ADD;
  logic [KEY_BITS-1:0]    key = '0;
  logic [HANDLE_BITS-1:0] handle = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic [HANDLE_BITS-1:0] item_handle;
  logic [KEY_BITS-1:0]    item_key;
  logic [CNT_BITS-1:0]    count;

  double_ended_bucket_priority_queue_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .key        (key),
    .handle     (handle),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .item_handle(item_handle),
    .item_key   (item_key),
    .count      (count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  queue_op_t     pending_ops[$];
  queue_result_t due_results[$];

  // shadow copy of the sorted row
  logic [KEY_BITS-1:0]    row_key[CAPACITY];
  logic [HANDLE_BITS-1:0] row_handle[CAPACITY];
  int                     row_held = 0;

  int total_n = 1;
  int accepted_n = 0;
  int err_n = 0;
  int checked_n = 0;
  int full_reject_n = 0;
  int empty_take_n = 0;
  int take_n = 0;
  int peak_held = 0;
  int est_held = 0;

  queue_op_t     sent_op;
  queue_result_t got_want;
  queue_result_t seen_want;

  function automatic queue_result_t apply_queue_op(queue_op_t op);
    queue_result_t res;
    int            pos;
    res.status      = STATUS_DONE;
    res.item_handle = '0;
    res.item_key    = '0;
    if (op.kind == KIND_ADD) begin
      if (row_held >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < row_held && row_key[pos] <= op.key) pos++;
        for (int i = row_held; i > pos; i--) begin
          row_key[i]    = row_key[i-1];
          row_handle[i] = row_handle[i-1];
        end
        row_key[pos]    = op.key;
        row_handle[pos] = op.handle;
        row_held++;
      end
    end else if (op.kind == KIND_TAKE_LOW || op.kind == KIND_TAKE_HIGH) begin
      if (row_held == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        pos = 0;
        if (op.kind == KIND_TAKE_HIGH) begin
          // oldest of the top key group
          pos = row_held - 1;
          while (pos > 0 && row_key[pos-1] == row_key[row_held-1]) pos--;
        end
        res.item_key    = row_key[pos];
        res.item_handle = row_handle[pos];
        for (int i = pos; i < row_held - 1; i++) begin
          row_key[i]    = row_key[i+1];
          row_handle[i] = row_handle[i+1];
        end
        row_held--;
      end
    end
    res.count = CNT_BITS'(row_held);
    return res;
  endfunction

  function automatic int sender_idle_pct();
    int phase;
    phase = accepted_n * 3 / total_n;
    return (phase == 0) ? 21 : (phase == 1) ? 77 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    int phase;
    phase = accepted_n * 3 / total_n;
    return (phase == 0) ? 77 : (phase == 1) ? 21 : 0;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_n++;
    end
  endfunction

  function automatic void queue_push(logic [1:0] k, logic [KEY_BITS-1:0] ky,
                                     logic [HANDLE_BITS-1:0] h);
    queue_op_t op;
    op.kind   = k;
    op.key    = ky;
    op.handle = h;
    pending_ops.push_back(op);
    if (k == KIND_ADD && est_held < CAPACITY) est_held++;
    else if ((k == KIND_TAKE_LOW || k == KIND_TAKE_HIGH) && est_held > 0) est_held--;
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key(int style);
    case (style)
      0: pick_key = KEY_BITS'($urandom_range(0, 3));
      1: pick_key = ($urandom_range(0, 1) != 0) ? '1 : '0;
      2: pick_key = KEY_BITS'($urandom_range(250, 255));
      default: pick_key = KEY_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [1:0] pick_take();
    return ($urandom_range(0, 1) != 0) ? KIND_TAKE_HIGH : KIND_TAKE_LOW;
  endfunction

  // driver: a transaction is predicted at the edge that accepts it
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sent_op = pending_ops.pop_front();
        got_want = apply_queue_op(sent_op);
        due_results.push_back(got_want);
        accepted_n++;
        if (got_want.status == STATUS_FULL) full_reject_n++;
        if (got_want.status == STATUS_EMPTY) empty_take_n++;
        if (got_want.status == STATUS_DONE && sent_op.kind != KIND_ADD &&
            sent_op.kind != KIND_NOP) take_n++;
        if (row_held > peak_held) peak_held = row_held;
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          in_valid <= 1'b1;
          kind     <= pending_ops[0].kind;
          key      <= pending_ops[0].key;
          handle   <= pending_ops[0].handle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none outstanding, actual status %0h handle %0h key %0h",
                   $time, status, item_handle, item_key);
          err_n++;
        end else begin
          seen_want = due_results.pop_front();
          check_field("status", 32'(seen_want.status), 32'(status));
          check_field("item_handle", 32'(seen_want.item_handle), 32'(item_handle));
          check_field("item_key", 32'(seen_want.item_key), 32'(item_key));
          check_field("count", 32'(seen_want.count), 32'(count));
          checked_n++;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  initial begin
    int seg;
    int style;
    int len;
    int roll;
    int directed_n;

    // empty takes, extreme keys and handles, equal-key order from both ends
    queue_push(KIND_TAKE_LOW, '1, '1);
    queue_push(KIND_TAKE_HIGH, '0, '0);
    queue_push(KIND_ADD, '0, '0);
    queue_push(KIND_ADD, '1, '1);
    queue_push(KIND_ADD, '1, 16'h1234);
    queue_push(KIND_ADD, '0, 16'haaaa);
    queue_push(KIND_ADD, 8'h80, 16'h5555);
    queue_push(KIND_NOP, '1, '1);
    queue_push(KIND_TAKE_HIGH, '1, '1);
    queue_push(KIND_TAKE_LOW, '0, '0);
    queue_push(KIND_TAKE_HIGH, 8'h55, 16'h00ff);
    queue_push(KIND_TAKE_HIGH, 8'haa, 16'hff00);
    queue_push(KIND_TAKE_LOW, '0, '0);
    queue_push(KIND_TAKE_LOW, '0, '0);
    queue_push(KIND_TAKE_HIGH, '0, '0);
    queue_push(KIND_NOP, '0, '0);
    queue_push(KIND_ADD, 8'h7f, 16'h8001);
    queue_push(KIND_TAKE_HIGH, '0, '0);
    directed_n = pending_ops.size();

    seg = 0;
    while (pending_ops.size() < directed_n + RANDOM_ITEMS) begin
      style = $urandom_range(0, 4);
      case (seg)
        0: begin
          // fill to capacity, then push a few into the full row
          len = $urandom_range(1, 4);
          while (est_held < CAPACITY)
            queue_push(KIND_ADD, pick_key(style), HANDLE_BITS'($urandom));
          repeat (len) queue_push(KIND_ADD, pick_key(style), HANDLE_BITS'($urandom));
        end
        1: begin
          // drain to empty, then take past the bottom
          len = $urandom_range(1, 3);
          while (est_held > 0)
            queue_push(pick_take(), KEY_BITS'($urandom), HANDLE_BITS'($urandom));
          repeat (len) queue_push(pick_take(), KEY_BITS'($urandom), HANDLE_BITS'($urandom));
        end
        default: begin
          len = $urandom_range(10, 40);
          repeat (len) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
              queue_push(KIND_NOP, KEY_BITS'($urandom), HANDLE_BITS'($urandom));
            else if (roll < 52)
              queue_push(KIND_ADD, pick_key(style), HANDLE_BITS'($urandom));
            else
              queue_push(pick_take(), KEY_BITS'($urandom), HANDLE_BITS'($urandom));
          end
        end
      endcase
      seg = (seg == 0) ? 2 : $urandom_range(0, 3);
    end
    total_n = pending_ops.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d transactions: %0d successful takes, %0d empty takes, %0d full rejects",
             accepted_n, take_n, empty_take_n, full_reject_n);
    $display("peak occupancy %0d of %0d, %0d results checked", peak_held, CAPACITY, checked_n);
    if (err_n == 0) begin
      $display("double_ended_bucket_priority_queue_unit_test: done, clean");
    end else begin
      $display("double_ended_bucket_priority_queue_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", due_results.size() + pending_ops.size());
    $display("double_ended_bucket_priority_queue_unit_test: done, errors");
    $finish;
  end

endmodule

### filelist.f
src/dbpq_pkg.sv
src/dbpq_cell.sv
src/double_ended_bucket_priority_queue_unit.sv
verif/double_ended_bucket_priority_queue_unit_test.sv
